FILE: sv/scs1a_pkg.sv
// Package: shared types, key codes and the scan code set 1 character tables.
package scs1a_pkg;

    localparam int unsigned QueueDepthDefault = 2;

    localparam logic [7:0] PrefixExt   = 8'hE0;
    localparam logic [6:0] KeyCtrl     = 7'h1D;
    localparam logic [6:0] KeyLShift   = 7'h2A;
    localparam logic [6:0] KeyRShift   = 7'h36;
    localparam logic [6:0] KeyCaps     = 7'h3A;
    localparam logic [6:0] KeyAlt      = 7'h38;
    localparam logic [6:0] KeyFirst    = 7'h01;
    localparam logic [6:0] KeyLast     = 7'h3A;
    localparam logic [6:0] CharLowerD  = 7'h64;
    localparam logic [6:0] CharCtrlD   = 7'h03;
    localparam logic [6:0] CaseBit     = 7'h20;

    // one word handed from the front end to the output queue
    typedef struct packed {
        logic       push;
        logic [6:0] ch;
    } item_t;

    // digit and punctuation keys: only Shift selects the shifted column
    function automatic logic shift_only(input logic [5:0] idx);
        logic r;
        r = 1'b0;
        if (idx < 6'h0E) r = 1'b1;
        case (idx)
            6'h1A, 6'h1B, 6'h27, 6'h28, 6'h29, 6'h2B, 6'h33, 6'h34, 6'h35: r = 1'b1;
            default: ;
        endcase
        return r;
    endfunction

    function automatic logic [6:0] plain_char(input logic [5:0] idx);
        logic [6:0] c;
        case (idx)
            6'h01: c = 7'h1B; 6'h02: c = 7'h31; 6'h03: c = 7'h32; 6'h04: c = 7'h33;
            6'h05: c = 7'h34; 6'h06: c = 7'h35; 6'h07: c = 7'h36; 6'h08: c = 7'h37;
            6'h09: c = 7'h38; 6'h0A: c = 7'h39; 6'h0B: c = 7'h30; 6'h0C: c = 7'h2D;
            6'h0D: c = 7'h3D; 6'h0E: c = 7'h08; 6'h0F: c = 7'h09;
            6'h10: c = 7'h71; 6'h11: c = 7'h77; 6'h12: c = 7'h65; 6'h13: c = 7'h72;
            6'h14: c = 7'h74; 6'h15: c = 7'h79; 6'h16: c = 7'h75; 6'h17: c = 7'h69;
            6'h18: c = 7'h6F; 6'h19: c = 7'h70; 6'h1A: c = 7'h5B; 6'h1B: c = 7'h5D;
            6'h1C: c = 7'h0A;
            6'h1E: c = 7'h61; 6'h1F: c = 7'h73; 6'h20: c = 7'h64; 6'h21: c = 7'h66;
            6'h22: c = 7'h67; 6'h23: c = 7'h68; 6'h24: c = 7'h6A; 6'h25: c = 7'h6B;
            6'h26: c = 7'h6C; 6'h27: c = 7'h3B; 6'h28: c = 7'h27; 6'h29: c = 7'h60;
            6'h2B: c = 7'h5C;
            6'h2C: c = 7'h7A; 6'h2D: c = 7'h78; 6'h2E: c = 7'h63; 6'h2F: c = 7'h76;
            6'h30: c = 7'h62; 6'h31: c = 7'h6E; 6'h32: c = 7'h6D; 6'h33: c = 7'h2C;
            6'h34: c = 7'h2E; 6'h35: c = 7'h2F; 6'h37: c = 7'h2A; 6'h39: c = 7'h20;
            default: c = 7'h00;
        endcase
        return c;
    endfunction

    function automatic logic [6:0] shifted_char(input logic [5:0] idx);
        logic [6:0] p;
        logic [6:0] c;
        p = plain_char(idx);
        case (idx)
            6'h02: c = 7'h21; 6'h03: c = 7'h40; 6'h04: c = 7'h23; 6'h05: c = 7'h24;
            6'h06: c = 7'h25; 6'h07: c = 7'h5E; 6'h08: c = 7'h26; 6'h09: c = 7'h2A;
            6'h0A: c = 7'h28; 6'h0B: c = 7'h29; 6'h0C: c = 7'h5F; 6'h0D: c = 7'h2B;
            6'h1A: c = 7'h7B; 6'h1B: c = 7'h7D; 6'h27: c = 7'h3A; 6'h28: c = 7'h22;
            6'h29: c = 7'h7E; 6'h2B: c = 7'h7C; 6'h33: c = 7'h3C; 6'h34: c = 7'h3E;
            6'h35: c = 7'h3F;
            default: begin
                // letters flip case, everything else is the same in both columns
                if (p >= 7'h61 && p <= 7'h7A) c = p ^ CaseBit;
                else c = p;
            end
        endcase
        return c;
    endfunction

endpackage

FILE: sv/scs1a_front.sv
// Front end: accepts scan bytes, tracks modifier flags and produces characters.
module scs1a_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                accept,
    input  logic [7:0]          scan_byte,
    output scs1a_pkg::item_t    item
);

    logic ext_reg,   ext_next;
    logic ctrl_reg,  ctrl_next;
    logic shift_reg, shift_next;
    logic caps_reg,  caps_next;

    logic [6:0] key;
    logic [5:0] idx;
    logic       in_table;
    logic       use_shift;
    logic [6:0] ch;

    assign key      = scan_byte[6:0];
    assign idx      = key[5:0];
    assign in_table = (key >= scs1a_pkg::KeyFirst) && (key <= scs1a_pkg::KeyLast);

    always_comb begin
        use_shift = scs1a_pkg::shift_only(idx) ? shift_reg : (shift_reg ^ caps_reg);
        ch = use_shift ? scs1a_pkg::shifted_char(idx) : scs1a_pkg::plain_char(idx);
        if (ctrl_reg && ch == scs1a_pkg::CharLowerD) ch = scs1a_pkg::CharCtrlD;
    end

    always_comb begin
        ext_next   = ext_reg;
        ctrl_next  = ctrl_reg;
        shift_next = shift_reg;
        caps_next  = caps_reg;
        item.push  = 1'b0;
        item.ch    = ch;
        if (accept) begin
            if (scan_byte == scs1a_pkg::PrefixExt) begin
                ext_next = 1'b1;
            end else begin
                ext_next = 1'b0;
                if (scan_byte[7]) begin
                    // break: right Ctrl releases like left, extended Shift does not
                    if (key == scs1a_pkg::KeyCtrl) begin
                        ctrl_next = 1'b0;
                    end else if (!ext_reg && (key == scs1a_pkg::KeyLShift ||
                                              key == scs1a_pkg::KeyRShift)) begin
                        shift_next = 1'b0;
                    end
                end else if (ext_reg) begin
                    if (key == scs1a_pkg::KeyCtrl) ctrl_next = 1'b1;
                end else if (in_table) begin
                    if (ch != 7'h00) begin
                        item.push = 1'b1;
                    end else if (key == scs1a_pkg::KeyCtrl) begin
                        ctrl_next = 1'b1;
                    end else if (key == scs1a_pkg::KeyLShift ||
                                 key == scs1a_pkg::KeyRShift) begin
                        shift_next = 1'b1;
                    end else if (key == scs1a_pkg::KeyCaps) begin
                        caps_next = ~caps_reg;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ext_reg   <= 1'b0;
            ctrl_reg  <= 1'b0;
            shift_reg <= 1'b0;
            caps_reg  <= 1'b0;
        end else begin
            ext_reg   <= ext_next;
            ctrl_reg  <= ctrl_next;
            shift_reg <= shift_next;
            caps_reg  <= caps_next;
        end
    end

endmodule

FILE: sv/scs1a_queue.sv
// Output queue: small FIFO of characters between the front end and the result port.
module scs1a_queue #(
    parameter int unsigned DEPTH = scs1a_pkg::QueueDepthDefault
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  scs1a_pkg::item_t    item,
    output logic                full,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [6:0]          out_ch
);

    localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CntW = $clog2(DEPTH + 1);
    localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);
    localparam logic [CntW-1:0] CntFull = CntW'(DEPTH);

    logic [6:0]      mem [DEPTH];
    logic [PtrW-1:0] wr_reg, wr_next;
    logic [PtrW-1:0] rd_reg, rd_next;
    logic [CntW-1:0] cnt_reg, cnt_next;
    logic            pop;

    assign full      = (cnt_reg == CntFull);
    assign out_valid = (cnt_reg != '0);
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (item.push) wr_next = (wr_reg == PtrLast) ? '0 : wr_reg + PtrW'(1);
        if (pop)       rd_next = (rd_reg == PtrLast) ? '0 : rd_reg + PtrW'(1);
        if (item.push && !pop)      cnt_next = cnt_reg + CntW'(1);
        else if (pop && !item.push) cnt_next = cnt_reg - CntW'(1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (item.push) mem[wr_reg] <= item.ch;
    end

    assign out_ch = mem[rd_reg];

endmodule

FILE: sv/scancode_set1_to_ascii_core.sv
// Top level: scan code set 1 to ASCII decoder with stream ports.
// Usage:
//   The slave channel (s_tvalid/s_tready/s_tdata) takes one raw set 1 scan byte
//   per word. The master channel (m_tvalid/m_tready/m_tdata) gives one ASCII
//   character per word for each make code that maps to a nonzero character.
//   Prefix, break and modifier bytes update the Ctrl, Shift, Caps and prefix
//   flags and produce no word.
// Output: a character is written into the FIFO when its byte is taken.
// Throughput: one byte per cycle unless the FIFO is full; the front end
//   classifies and updates flags in the accept cycle, and a QUEUE_DEPTH-entry FIFO holds characters.
// Stall: while the master side is stalled, bytes are still taken until the
//   FIFO fills; s_tready drops only when all QUEUE_DEPTH entries are in use.
// Reset: aresetn (synchronous, active low) clears all flags and empties the
//   FIFO; no words are lost or created across a stall.
module scancode_set1_to_ascii_core #(
    parameter int unsigned QUEUE_DEPTH = scs1a_pkg::QueueDepthDefault
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] scan_byte
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata    // [6:0] ascii_char, [7] zero
);

    scs1a_pkg::item_t item;
    logic             full;
    logic [6:0]       out_ch;

    assign s_tready = ~full;

    scs1a_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (s_tvalid & s_tready),
        .scan_byte (s_tdata),
        .item      (item)
    );

    scs1a_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .item      (item),
        .full      (full),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_ch    (out_ch)
    );

    assign m_tdata = {1'b0, out_ch};

endmodule

FILE: sv/scs1a_checker.sv
// Checker: port-level assertions for the decoder, bound to the top level.
module scs1a_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic [7:0] s_tdata,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata
);

    // a stalled word holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled output word changed");

    a_ascii: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !m_tdata[7])
        else $error("output word outside ASCII range");

    // prefix and break bytes never produce a word
    a_break: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tdata[7] && !m_tvalid |=> !m_tvalid)
        else $error("break or prefix byte produced a word");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("output valid or input stalled after reset");

endmodule

bind scancode_set1_to_ascii_core scs1a_checker u_scs1a_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
